// ===== sv/salb_pkg.sv =====
// ----------------------------------------------------------------------------
// salb_pkg
// Shared widths, limits and codes of the suffix array / LCP builder.
// ----------------------------------------------------------------------------
package salb_pkg;

	localparam int MAX_LEN = 1024;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CH_W    = 7;
	localparam int HGT_W   = 10;
	localparam int KEY_W   = LEN_W;
	localparam int PAIR_W  = 3 * KEY_W;
	localparam int CNT_TOP = MAX_LEN;

	localparam logic FN_LOAD = 1'b0;
	localparam logic FN_READ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

// ===== sv/suffix_array_lcp_builder_unit.sv =====
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_unit
// Loads a text, builds its suffix array by prefix doubling with radix
// counting sorts, fills LCP heights with a Kasai pass, and serves reads.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | in_valid, in_stall | func, ch, last, rank_index
//  output  | out_valid, out_stall| position, lcp_height, text_length, status
//
//  A load answers straight from the output registers; a read first passes through the synchronous memory read.
//  A load with last starts the build; the input stalls until it ends. Each
//  doubling round sweeps the count memory over 1025 entries, there are at
//  most 1 + ceil(log2(n)) rounds, and an order pass and a height pass follow.
//  Reset clears the fill count and the built flag; the memories are not cleared.
//  A stalled output holds the input.
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder_unit import salb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [CH_W-1:0]   ch,
	input  logic              last,
	input  logic [LEN_W-1:0]  rank_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [LEN_W-1:0]  position,
	output logic [HGT_W-1:0]  lcp_height,
	output logic [LEN_W-1:0]  text_length,
	output logic [1:0]        status
);

	typedef enum logic [4:0] {
		S_IDLE, S_PB_RD1, S_PB_RD2, S_PB_WR,
		S_CLR, S_CNT_RD, S_CNT_KEY, S_CNT_WR, S_SUM_RD, S_SUM_WR,
		S_SC_RD, S_SC_KEY, S_SC_WR, S_RK_RD, S_RK_WR, S_NEXT,
		S_SA_RD, S_SA_WR, S_KA_RD, S_KA_R, S_KA_J, S_KA_C1, S_KA_C2, S_KA_C3
	} state_t;

	state_t               st_q;
	logic [LEN_W-1:0]     count_q, n_q, len_q, i_q, tot_q, acc_q, r_q, j_q, first_q;
	logic [LEN_W-1:0]     key_q;
	logic [HGT_W-1:0]     k_q;
	logic [CH_W-1:0]      t1_q;
	logic [PAIR_W-1:0]    item_q;
	logic [2*KEY_W-1:0]   prev_q;
	logic                 built_q, round0_q, pass_q, pend_s1, ok_s1, out_valid_q;
	logic [LEN_W-1:0]     position_q, text_length_q;
	logic [HGT_W-1:0]     lcp_height_q;
	logic [1:0]           status_q;

	logic [CH_W-1:0]   text_mem [MAX_LEN];
	logic [LEN_W-1:0]  sa_mem   [MAX_LEN];
	logic [LEN_W-1:0]  rank_mem [MAX_LEN];
	logic [HGT_W-1:0]  hgt_mem  [MAX_LEN];
	logic [LEN_W-1:0]  cnt_mem  [CNT_TOP+1];
	logic [PAIR_W-1:0] pb_mem   [MAX_LEN];
	logic [PAIR_W-1:0] scr_mem  [MAX_LEN];

	logic              text_we, sa_we, rank_we, hgt_we, cnt_we, pb_we, scr_we;
	logic [ADDR_W-1:0] text_addr, sa_addr, rank_addr, hgt_addr, pb_addr, scr_addr;
	logic [KEY_W-1:0]  cnt_addr;
	logic [CH_W-1:0]   text_rd;
	logic [LEN_W-1:0]  sa_rd, rank_rd, cnt_rd, sa_wd, rank_wd, cnt_wd;
	logic [HGT_W-1:0]  hgt_rd, hgt_wd;
	logic [PAIR_W-1:0] pb_rd, scr_rd, pair_wd;

	logic              accept, load_go, read_go, full, last_i, cmp_ok, pb_sec_ok, newgrp;
	logic              cont, rd_ok;
	logic [LEN_W-1:0]  base, new_count, tot_new, nlen, cnt_dec, src_key, item_key;
	logic [LEN_W:0]    ik, jk, il;
	logic [HGT_W-1:0]  k_dec;
	logic [PAIR_W-1:0] src_rd;

	assign in_stall    = (st_q != S_IDLE) || pend_s1 || (out_valid_q && out_stall);
	assign accept      = in_valid && !in_stall;
	assign load_go     = accept && (func == FN_LOAD);
	assign read_go     = accept && (func == FN_READ);
	assign base        = built_q ? '0 : count_q;
	assign full        = (base >= LEN_W'(MAX_LEN));
	assign new_count   = full ? base : base + 1'b1;
	assign rd_ok       = built_q && (rank_index != '0) && (rank_index <= count_q);

	assign src_rd      = pass_q ? scr_rd : pb_rd;
	assign src_key     = pass_q ? src_rd[PAIR_W-1 -: KEY_W] : src_rd[2*KEY_W-1 -: KEY_W];
	assign item_key    = pass_q ? item_q[PAIR_W-1 -: KEY_W] : item_q[2*KEY_W-1 -: KEY_W];
	assign cnt_dec     = cnt_rd - 1'b1;

	assign il          = {1'b0, i_q} + {1'b0, len_q};
	assign pb_sec_ok   = !round0_q && (il <= {1'b0, n_q});
	assign newgrp      = (i_q == LEN_W'(1)) || (pb_rd[PAIR_W-1 -: 2*KEY_W] != prev_q);
	assign tot_new     = newgrp ? tot_q + 1'b1 : tot_q;
	assign nlen        = round0_q ? LEN_W'(1) : {len_q[LEN_W-2:0], 1'b0};
	assign cont        = (nlen < n_q) && (tot_q < n_q);
	assign last_i      = (i_q == n_q);

	assign ik          = {1'b0, i_q} + {{(LEN_W+1-HGT_W){1'b0}}, k_q};
	assign jk          = {1'b0, j_q} + {{(LEN_W+1-HGT_W){1'b0}}, k_q};
	assign cmp_ok      = (ik <= {1'b0, n_q}) && (jk <= {1'b0, n_q});
	assign k_dec       = (k_q != '0) ? k_q - 1'b1 : '0;

	always_comb begin
		text_we   = 1'b0;
		text_addr = ADDR_W'(i_q - 1'b1);
		sa_we     = 1'b0;
		sa_addr   = ADDR_W'(rank_index - 1'b1);
		sa_wd     = i_q;
		rank_we   = 1'b0;
		rank_addr = ADDR_W'(i_q - 1'b1);
		rank_wd   = tot_new;
		hgt_we    = 1'b0;
		hgt_addr  = ADDR_W'(rank_index - 1'b1);
		hgt_wd    = k_q;
		cnt_we    = 1'b0;
		cnt_addr  = acc_q;
		cnt_wd    = '0;
		pb_we     = 1'b0;
		pb_addr   = ADDR_W'(i_q - 1'b1);
		scr_we    = 1'b0;
		scr_addr  = ADDR_W'(i_q - 1'b1);
		pair_wd   = {first_q, (pb_sec_ok ? rank_rd : LEN_W'(0)), i_q};
		unique case (st_q)
			S_IDLE: begin
				text_addr = ADDR_W'(base);
				text_we   = load_go && !full;
			end
			S_PB_RD2: rank_addr = ADDR_W'(il - 1'b1);
			S_PB_WR:  pb_we = 1'b1;
			S_CLR: begin
				cnt_we   = 1'b1;
				cnt_addr = key_q;
			end
			S_CNT_KEY: cnt_addr = src_key;
			S_CNT_WR: begin
				cnt_we   = 1'b1;
				cnt_addr = key_q;
				cnt_wd   = cnt_rd + 1'b1;
			end
			S_SUM_RD: cnt_addr = key_q;
			S_SUM_WR: begin
				cnt_we   = 1'b1;
				cnt_addr = key_q;
				cnt_wd   = acc_q + cnt_rd;
			end
			S_SC_KEY: cnt_addr = src_key;
			S_SC_WR: begin
				cnt_we   = 1'b1;
				cnt_addr = item_key;
				cnt_wd   = cnt_dec;
				pair_wd  = item_q;
				pb_addr  = ADDR_W'(cnt_dec);
				scr_addr = ADDR_W'(cnt_dec);
				pb_we    = pass_q;
				scr_we   = !pass_q;
			end
			S_RK_WR: begin
				rank_we   = 1'b1;
				rank_addr = ADDR_W'(pb_rd[KEY_W-1:0] - 1'b1);
			end
			S_SA_WR: begin
				sa_we   = 1'b1;
				sa_addr = ADDR_W'(rank_rd - 1'b1);
			end
			S_KA_R: begin
				sa_addr  = ADDR_W'(rank_rd - LEN_W'(2));
				hgt_addr = '0;
				hgt_wd   = '0;
				hgt_we   = (rank_rd == LEN_W'(1));
			end
			S_KA_C1: begin
				text_addr = ADDR_W'(ik - 1'b1);
				hgt_addr  = ADDR_W'(r_q - 1'b1);
				hgt_we    = !cmp_ok;
			end
			S_KA_C2: text_addr = ADDR_W'(jk - 1'b1);
			S_KA_C3: begin
				hgt_addr = ADDR_W'(r_q - 1'b1);
				hgt_we   = (text_rd != t1_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (text_we) text_mem[text_addr] <= ch;
		text_rd <= text_mem[text_addr];
	end

	always_ff @(posedge clk) begin
		if (sa_we) sa_mem[sa_addr] <= sa_wd;
		sa_rd <= sa_mem[sa_addr];
	end

	always_ff @(posedge clk) begin
		if (rank_we) rank_mem[rank_addr] <= rank_wd;
		rank_rd <= rank_mem[rank_addr];
	end

	always_ff @(posedge clk) begin
		if (hgt_we) hgt_mem[hgt_addr] <= hgt_wd;
		hgt_rd <= hgt_mem[hgt_addr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_addr] <= cnt_wd;
		cnt_rd <= cnt_mem[cnt_addr];
	end

	always_ff @(posedge clk) begin
		if (pb_we) pb_mem[pb_addr] <= pair_wd;
		pb_rd <= pb_mem[pb_addr];
	end

	always_ff @(posedge clk) begin
		if (scr_we) scr_mem[scr_addr] <= pair_wd;
		scr_rd <= scr_mem[scr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			built_q     <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (pend_s1) begin
				pend_s1       <= 1'b0;
				out_valid_q   <= 1'b1;
				position_q    <= ok_s1 ? sa_rd : '0;
				lcp_height_q  <= ok_s1 ? hgt_rd : '0;
				text_length_q <= count_q;
				status_q      <= ok_s1 ? ST_OK : ST_RANGE;
			end
			unique case (st_q)
				S_IDLE: begin
					if (read_go) begin
						pend_s1 <= 1'b1;
						ok_s1   <= rd_ok;
					end
					if (load_go) begin
						built_q       <= 1'b0;
						count_q       <= new_count;
						out_valid_q   <= 1'b1;
						position_q    <= '0;
						lcp_height_q  <= '0;
						text_length_q <= new_count;
						status_q      <= full ? ST_FULL : ST_OK;
						if (last) begin
							st_q     <= S_PB_RD1;
							n_q      <= new_count;
							round0_q <= 1'b1;
							len_q    <= '0;
							i_q      <= LEN_W'(1);
						end
					end
				end
				S_PB_RD1: st_q <= S_PB_RD2;
				S_PB_RD2: begin
					first_q <= round0_q ? LEN_W'(text_rd) + 1'b1 : rank_rd;
					st_q    <= S_PB_WR;
				end
				S_PB_WR: begin
					if (last_i) begin
						pass_q <= 1'b0;
						key_q  <= '0;
						st_q   <= S_CLR;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_PB_RD1;
					end
				end
				S_CLR: begin
					if (key_q == KEY_W'(CNT_TOP)) begin
						i_q  <= LEN_W'(1);
						st_q <= S_CNT_RD;
					end else begin
						key_q <= key_q + 1'b1;
					end
				end
				S_CNT_RD: st_q <= S_CNT_KEY;
				S_CNT_KEY: begin
					key_q <= src_key;
					st_q  <= S_CNT_WR;
				end
				S_CNT_WR: begin
					if (last_i) begin
						key_q <= '0;
						acc_q <= '0;
						st_q  <= S_SUM_RD;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_CNT_RD;
					end
				end
				S_SUM_RD: st_q <= S_SUM_WR;
				S_SUM_WR: begin
					acc_q <= acc_q + cnt_rd;
					if (key_q == KEY_W'(CNT_TOP)) begin
						i_q  <= n_q;
						st_q <= S_SC_RD;
					end else begin
						key_q <= key_q + 1'b1;
						st_q  <= S_SUM_RD;
					end
				end
				S_SC_RD: st_q <= S_SC_KEY;
				S_SC_KEY: begin
					item_q <= src_rd;
					st_q   <= S_SC_WR;
				end
				S_SC_WR: begin
					if (i_q == LEN_W'(1)) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							key_q  <= '0;
							st_q   <= S_CLR;
						end else begin
							tot_q <= '0;
							st_q  <= S_RK_RD;
						end
					end else begin
						i_q  <= i_q - 1'b1;
						st_q <= S_SC_RD;
					end
				end
				S_RK_RD: st_q <= S_RK_WR;
				S_RK_WR: begin
					tot_q  <= tot_new;
					prev_q <= pb_rd[PAIR_W-1 -: 2*KEY_W];
					if (last_i) begin
						st_q <= S_NEXT;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_RK_RD;
					end
				end
				S_NEXT: begin
					round0_q <= 1'b0;
					len_q    <= nlen;
					i_q      <= LEN_W'(1);
					st_q     <= cont ? S_PB_RD1 : S_SA_RD;
				end
				S_SA_RD: st_q <= S_SA_WR;
				S_SA_WR: begin
					i_q <= last_i ? LEN_W'(1) : i_q + 1'b1;
					if (last_i) begin
						k_q  <= '0;
						st_q <= S_KA_RD;
					end else begin
						st_q <= S_SA_RD;
					end
				end
				S_KA_RD: st_q <= S_KA_R;
				S_KA_R: begin
					r_q <= rank_rd;
					if (rank_rd == LEN_W'(1)) begin
						k_q <= '0;
						if (last_i) begin
							built_q <= 1'b1;
							st_q    <= S_IDLE;
						end else begin
							i_q  <= i_q + 1'b1;
							st_q <= S_KA_RD;
						end
					end else begin
						k_q  <= k_dec;
						st_q <= S_KA_J;
					end
				end
				S_KA_J: begin
					j_q  <= sa_rd;
					st_q <= S_KA_C1;
				end
				S_KA_C1: begin
					if (cmp_ok) begin
						st_q <= S_KA_C2;
					end else if (last_i) begin
						built_q <= 1'b1;
						st_q    <= S_IDLE;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_KA_RD;
					end
				end
				S_KA_C2: begin
					t1_q <= text_rd;
					st_q <= S_KA_C3;
				end
				S_KA_C3: begin
					if (text_rd == t1_q) begin
						k_q  <= k_q + 1'b1;
						st_q <= S_KA_C1;
					end else if (last_i) begin
						built_q <= 1'b1;
						st_q    <= S_IDLE;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_KA_RD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign position    = position_q;
	assign lcp_height  = lcp_height_q;
	assign text_length = text_length_q;
	assign status      = status_q;

endmodule

// ===== sv/salb_check.sv =====
// ----------------------------------------------------------------------------
// salb_check
// Port-level checks of the suffix array / LCP builder, bound to the top level.
// ----------------------------------------------------------------------------
module salb_check import salb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              func,
	input logic [CH_W-1:0]   ch,
	input logic              last,
	input logic [LEN_W-1:0]  rank_index,
	input logic              out_valid,
	input logic              out_stall,
	input logic [LEN_W-1:0]  position,
	input logic [HGT_W-1:0]  lcp_height,
	input logic [LEN_W-1:0]  text_length,
	input logic [1:0]        status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(status))
		else $error("output dropped or changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> position == '0 && lcp_height == '0)
		else $error("failed transfer carries data");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> text_length == LEN_W'(MAX_LEN))
		else $error("load dropped below capacity");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> position <= text_length)
		else $error("position beyond text length");

endmodule

bind suffix_array_lcp_builder_unit salb_check u_salb_check (.*);
